### rtl/core/bdar_pkg.sv
`default_nettype none

package bdar_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned MS16_W   = 16;
	localparam int unsigned CHECK_W  = 8;
	localparam int unsigned REPEAT_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE       = 3'd0,
		REG_ACTIVE_LEVEL = 3'd1,
		REG_DEBOUNCE_MS  = 3'd2,
		REG_REPEAT_MS    = 3'd3,
		REG_CHECK_PERIOD = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic               enable;
		logic               active_level;
		logic [MS16_W-1:0]  debounce_ms;
		logic [MS16_W-1:0]  repeat_ms;
		logic [CHECK_W-1:0] check_period_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		enable:          1'b0,
		active_level:    1'b0,
		debounce_ms:     16'd50,
		repeat_ms:       16'd0,
		check_period_ms: 8'd10
	};

	typedef struct packed {
		logic                first_sample;
		logic                stable_level;
		logic [TIME_W-1:0]   time_in_state;
		logic [TIME_W-1:0]   last_sample_time;
		logic [TIME_W-1:0]   last_repeat_time;
		logic [REPEAT_W-1:0] repeat_counter;
	} state_t;

	localparam state_t STATE_RESET = '{
		first_sample:     1'b1,
		stable_level:     1'b0,
		time_in_state:    '0,
		last_sample_time: '0,
		last_repeat_time: '0,
		repeat_counter:   '0
	};

	typedef struct packed {
		logic                active;
		logic [TIME_W-1:0]   duration_ms;
		logic [REPEAT_W-1:0] repeat_number;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/bdar_ifs.sv
`default_nettype none

interface bdar_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        pin_level;

	modport source (output valid, output now_ms, output pin_level, input ready);
	modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

interface bdar_out_if;
	logic        valid;
	logic        ready;
	logic        active;
	logic [31:0] duration_ms;
	logic [15:0] repeat_number;

	modport source (output valid, output active, output duration_ms,
		output repeat_number, input ready);
	modport sink   (input valid, input active, input duration_ms,
		input repeat_number, output ready);
endinterface

`default_nettype wire

### rtl/core/button_debounce_autorepeat.sv
`default_nettype none

// Push-button debouncer with auto-repeat.
// in_ch carries one beat per pin sample: a free-running millisecond
// timestamp (wrapping) and the raw pin level. out_ch carries button events:
// the debounced level, the time spent in the state, and a repeat index
// (0 for a state change, counting up for auto-repeats while pressed).
// Most input beats produce no event; at most one event follows a beat.
//
// Timing: an accepted beat lands in the stage-1 register; when stage 1
// advances, the debounce/repeat update commits and any event is written
// to the output register, from which it is offered on out_ch.
// The update is one subtract/add/compare pass, so a beat is taken every cycle unless a stall holds it.
// Stalls: while an undelivered event sits in the output register, stage 1
// holds its beat and in_ch.ready drops (an empty stage 1 first takes one
// more beat); in_ch.ready follows out_ch.ready in the same cycle.
//
// Reset clears the debounce state (next sample only seeds the level), both
// valid flags, and loads the register defaults: disabled, pressed = pin low,
// 50 ms debounce, no repeat, 10 ms check period. Write the registers over
// the cfg port only while the block is idle.
module button_debounce_autorepeat (
	input  logic                                clk,
	input  logic                                arst_n,
	bdar_in_if.sink                             in_ch,
	bdar_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [bdar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bdar_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bdar_pkg::*;

	cfg_t              cfg_q;
	state_t            state_q;
	state_t            nxt_state;
	logic              emit;
	result_t           result;

	logic              valid_s1;
	logic [TIME_W-1:0] now_ms_s1;
	logic              pin_level_s1;

	logic              out_valid_q;
	result_t           out_q;

	logic              advance;

	// stage 1 may advance whenever the output slot is free or draining
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:       cfg_q.enable          <= cfg_data[0];
				REG_ACTIVE_LEVEL: cfg_q.active_level    <= cfg_data[0];
				REG_DEBOUNCE_MS:  cfg_q.debounce_ms     <= cfg_data[MS16_W-1:0];
				REG_REPEAT_MS:    cfg_q.repeat_ms       <= cfg_data[MS16_W-1:0];
				REG_CHECK_PERIOD: cfg_q.check_period_ms <= cfg_data[CHECK_W-1:0];
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			now_ms_s1    <= in_ch.now_ms;
			pin_level_s1 <= in_ch.pin_level;
		end
	end

	bdar_step u_step (
		.cfg       (cfg_q),
		.cur_state (state_q),
		.now_ms    (now_ms_s1),
		.pin_level (pin_level_s1),
		.nxt_state (nxt_state),
		.emit      (emit),
		.result    (result)
	);

	// commit the debounce state once per advancing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= nxt_state;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.active        = out_q.active;
	assign out_ch.duration_ms   = out_q.duration_ms;
	assign out_ch.repeat_number = out_q.repeat_number;

endmodule

`default_nettype wire

### rtl/core/bdar_step.sv
`default_nettype none

module bdar_step (
	input  bdar_pkg::cfg_t               cfg,
	input  bdar_pkg::state_t             cur_state,
	input  logic [bdar_pkg::TIME_W-1:0]  now_ms,
	input  logic                         pin_level,
	output bdar_pkg::state_t             nxt_state,
	output logic                         emit,
	output bdar_pkg::result_t            result
);
	import bdar_pkg::*;

	logic [TIME_W-1:0]   elapsed;
	logic [TIME_W-1:0]   tis_sum;
	logic [TIME_W-1:0]   since_repeat;
	logic [REPEAT_W-1:0] count_inc;
	logic                sample;
	logic                level;

	assign elapsed      = now_ms - cur_state.last_sample_time;
	assign tis_sum      = cur_state.time_in_state + elapsed;
	assign since_repeat = now_ms - cur_state.last_repeat_time;
	assign count_inc    = cur_state.repeat_counter + REPEAT_W'(1);
	assign sample       = cfg.enable &&
		(elapsed > {{(TIME_W-CHECK_W){1'b0}}, cfg.check_period_ms});
	assign level        = (pin_level == cfg.active_level);

	always_comb begin
		nxt_state = cur_state;
		emit      = 1'b0;
		result    = '{active: level, duration_ms: tis_sum, repeat_number: '0};
		if (sample) begin
			nxt_state.time_in_state    = tis_sum;
			nxt_state.last_sample_time = now_ms;
			priority if (cur_state.first_sample) begin
				// first sample only seeds the stable level
				nxt_state.stable_level = level;
				nxt_state.first_sample = 1'b0;
			end else if (level != cur_state.stable_level) begin
				if (tis_sum > {{(TIME_W-MS16_W){1'b0}}, cfg.debounce_ms}) begin
					nxt_state.stable_level     = level;
					nxt_state.time_in_state    = '0;
					nxt_state.last_repeat_time = now_ms;
					nxt_state.repeat_counter   = '0;
					emit                       = 1'b1;
				end
			end else if (level && (cfg.repeat_ms != '0) &&
				(since_repeat > {{(TIME_W-MS16_W){1'b0}}, cfg.repeat_ms})) begin
				nxt_state.last_repeat_time = now_ms;
				nxt_state.repeat_counter   = count_inc;
				result.repeat_number       = count_inc;
				emit                       = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### tb/bdar_event_checker.sv
`default_nettype none

module bdar_event_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	bdar_in_if                                in_ch,
	bdar_out_if                               out_ch,
	input  logic                              cfg_we,
	input  logic [bdar_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdar_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                mismatches,
	output int                                outstanding
);
	import bdar_pkg::*;

	cfg_t    regs;
	state_t  btn;
	result_t pending_events[$];

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (reg_index_t'(idx))
			REG_ENABLE:       regs.enable = data[0];
			REG_ACTIVE_LEVEL: regs.active_level = data[0];
			REG_DEBOUNCE_MS:  regs.debounce_ms = data[MS16_W-1:0];
			REG_REPEAT_MS:    regs.repeat_ms = data[MS16_W-1:0];
			REG_CHECK_PERIOD: regs.check_period_ms = data[CHECK_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the debounce state by one pin sample, queue the event it raises.
	function automatic void track_sample(input logic [TIME_W-1:0] now, input logic pin);
		logic [TIME_W-1:0] elapsed;
		logic              pressed;
		result_t           ev;
		if (!regs.enable)
			return;
		elapsed = now - btn.last_sample_time;
		if (elapsed <= regs.check_period_ms)
			return;
		btn.time_in_state = btn.time_in_state + elapsed;
		btn.last_sample_time = now;
		pressed = (pin == regs.active_level);
		if (btn.first_sample) begin
			btn.stable_level = pressed;
			btn.first_sample = 1'b0;
			return;
		end
		if (pressed != btn.stable_level) begin
			if (btn.time_in_state > regs.debounce_ms) begin
				btn.stable_level = pressed;
				ev.active = pressed;
				ev.duration_ms = btn.time_in_state;
				ev.repeat_number = '0;
				pending_events.push_back(ev);
				btn.time_in_state = '0;
				btn.last_repeat_time = now;
				btn.repeat_counter = '0;
			end
			return;
		end
		if (pressed && regs.repeat_ms != '0 && (now - btn.last_repeat_time) > regs.repeat_ms) begin
			btn.last_repeat_time = now;
			btn.repeat_counter = btn.repeat_counter + 1'b1;
			ev.active = pressed;
			ev.duration_ms = btn.time_in_state;
			ev.repeat_number = btn.repeat_counter;
			pending_events.push_back(ev);
		end
	endfunction

	function automatic void check_event(input result_t got);
		result_t want;
		if (pending_events.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected event active=%0d duration=%0d repeat=%0d",
					$realtime, got.active, got.duration_ms, got.repeat_number);
			return;
		end
		want = pending_events.pop_front();
		if (got.active !== want.active || got.duration_ms !== want.duration_ms ||
				got.repeat_number !== want.repeat_number) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t: event mismatch: expected active=%0d duration=%0d repeat=%0d,",
					" got active=%0d duration=%0d repeat=%0d"}, $realtime,
					want.active, want.duration_ms, want.repeat_number,
					got.active, got.duration_ms, got.repeat_number);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = CFG_RESET;
			btn = STATE_RESET;
			pending_events.delete();
			mismatches = 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_event('{out_ch.active, out_ch.duration_ms, out_ch.repeat_number});
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (in_ch.valid && in_ch.ready)
				track_sample(in_ch.now_ms, in_ch.pin_level);
		end
		outstanding = pending_events.size();
	end

endmodule

`default_nettype wire

### tb/tb_button_debounce_autorepeat.sv
`default_nettype none

module tb_button_debounce_autorepeat;
	import bdar_pkg::*;

	// Cycles without any accepted beat or register write before the run is called hung.
	localparam int QUIET_LIMIT = 2000;

	// Register settings for the random phases: defaults-like, all times zero, all times max,
	// fast repeat, disabled, slow repeat.
	localparam cfg_t PHASE_PLAN [6] = '{
		'{1'b1, 1'b0, 16'd50,    16'd100,   8'd10},
		'{1'b1, 1'b1, 16'd0,     16'd0,     8'd0},
		'{1'b1, 1'b1, 16'd65535, 16'd65535, 8'd255},
		'{1'b1, 1'b0, 16'd20,    16'd1,     8'd3},
		'{1'b0, 1'b1, 16'd30,    16'd40,    8'd5},
		'{1'b1, 1'b1, 16'd200,   16'd300,   8'd20}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	int                    sender_idle_pct;
	int                    recv_idle_pct;
	int                    quiet_cycles;
	logic [TIME_W-1:0]     wall_ms;
	logic                  held;

	bdar_in_if  in_ch ();
	bdar_out_if out_ch ();

	button_debounce_autorepeat DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bdar_event_checker u_events (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Stall the event sink at random; the idle share is set per phase.
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: count cycles in which nothing moves, give up at the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Offer one sample beat; call at a falling edge, returns at a falling edge
	// with valid still high so back-to-back beats need no gap.
	task automatic push_sample(input logic [TIME_W-1:0] now, input logic pin);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.now_ms    <= now;
		in_ch.pin_level <= pin;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Hold the sender until every predicted event has come out, then let the
	// pipeline settle in case the last beat is still being processed.
	task automatic drain_events();
		in_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		write_reg(REG_ENABLE, CFG_DATA_W'(c.enable));
		write_reg(REG_ACTIVE_LEVEL, CFG_DATA_W'(c.active_level));
		write_reg(REG_DEBOUNCE_MS, c.debounce_ms);
		write_reg(REG_REPEAT_MS, c.repeat_ms);
		write_reg(REG_CHECK_PERIOD, CFG_DATA_W'(c.check_period_ms));
		cfg_we <= 1'b0;
	endtask

	// Press-and-release traffic: a held level with contact bounce, time steps
	// scaled to the current settings, and now and then a wild jump in time.
	task automatic run_phase(input cfg_t c, input int beats);
		int                chk;
		int                span;
		int                pick;
		logic [TIME_W-1:0] step;
		logic              pin;
		chk = int'(c.check_period_ms);
		span = int'(c.debounce_ms > c.repeat_ms ? c.debounce_ms : c.repeat_ms) + chk + 2;
		for (int n = 0; n < beats; n++) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 7)
				held = ~held;
			pin = held ^ ($urandom_range(99) < 12);
			if (pick < 40)
				step = $urandom_range(chk * 2 + 2, 0);
			else if (pick < 85)
				step = $urandom_range(span / 3 + 1, 1);
			else if (pick < 95)
				step = $urandom_range(span * 2, span / 2);
			else begin
				step = $urandom;
				pin = $urandom_range(1);
			end
			wall_ms = wall_ms + step;
			push_sample(wall_ms, pin);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.now_ms    = '0;
		in_ch.pin_level = 1'b0;
		out_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_ENABLE;
		cfg_data        = '0;
		sender_idle_pct = 18;
		recv_idle_pct   = 79;
		held            = 1'b0;
		wall_ms         = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Block comes out of reset disabled: these beats must raise nothing.
		push_sample(32'd100, 1'b1);
		push_sample(32'd5000, 1'b0);
		drain_events();

		program_regs('{1'b1, 1'b1, 16'd50, 16'd30, 8'd10});
		// Elapsed equal to the check period is not a sample.
		push_sample(32'd10, 1'b0);
		// First sample only seeds the stable level.
		push_sample(32'd11, 1'b0);
		// Press, time in state reaches the debounce time exactly, then exceeds it.
		push_sample(32'd30, 1'b1);
		push_sample(32'd50, 1'b1);
		push_sample(32'd61, 1'b1);
		// Hold: repeat period met exactly, then exceeded twice.
		push_sample(32'd80, 1'b1);
		push_sample(32'd91, 1'b1);
		push_sample(32'd102, 1'b1);
		push_sample(32'd140, 1'b1);
		// Release, with one beat too early to be sampled.
		push_sample(32'd150, 1'b0);
		push_sample(32'd170, 1'b0);
		// Timestamp wraps past zero between two samples.
		push_sample(32'hFFFF_FFF0, 1'b0);
		push_sample(32'h0000_0010, 1'b1);
		// Two huge gaps while held: time in state wraps.
		push_sample(32'hC000_0010, 1'b1);
		push_sample(32'h8000_0010, 1'b1);
		wall_ms = 32'h8000_0010;
		held = 1'b1;

		for (int p = 0; p < 6; p++) begin
			drain_events();
			sender_idle_pct = (p < 2) ? 18 : (p < 4) ? 79 : 0;
			recv_idle_pct   = (p < 2) ? 79 : (p < 4) ? 18 : 0;
			program_regs(PHASE_PLAN[p]);
			run_phase(PHASE_PLAN[p], PHASE_PLAN[p].enable ? 350 : 60);
		end

		// Hold the button with a 1 ms repeat period so every sample raises an
		// event, back to back.
		drain_events();
		program_regs('{1'b1, 1'b1, 16'd0, 16'd1, 8'd0});
		for (int n = 0; n < 100; n++) begin
			wall_ms = wall_ms + 32'd2;
			push_sample(wall_ms, 1'b1);
		end

		drain_events();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
